### hw/rtl/alert_mode_sleep_scheduler_top_macros.svh
// Assertion macros used by the scheduler checker.
`ifndef ALERT_MODE_SLEEP_SCHEDULER_TOP_MACROS_SVH
`define ALERT_MODE_SLEEP_SCHEDULER_TOP_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define AMSS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("scheduler check failed");

// Next-cycle implication, ignored while reset is high.
`define AMSS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("scheduler check failed");

// Next-cycle implication that also holds across reset.
`define AMSS_ASSERT_RESET(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("scheduler reset check failed");

`endif

### hw/rtl/amss_pkg.sv
// Types and constants of the alert mode sleep scheduler.
`timescale 1ns / 1ps
`default_nettype none

package amss_pkg;

   localparam logic [1:0] CMD_ADVANCE = 2'd0;
   localparam logic [1:0] CMD_ANOMALY = 2'd1;
   localparam logic [1:0] CMD_REMOTE  = 2'd2;
   localparam logic [1:0] CMD_RISK    = 2'd3;

   localparam logic [2:0] REG_OWN_NODE_ID       = 3'd0;
   localparam logic [2:0] REG_DEF_ALERT_DUR     = 3'd1;
   localparam logic [2:0] REG_DEF_ALERT_IVL     = 3'd2;
   localparam logic [2:0] REG_RISK_THR_MEDIUM   = 3'd3;
   localparam logic [2:0] REG_RISK_THR_LOW      = 3'd4;
   localparam logic [2:0] REG_SLEEP_HIGH_RISK   = 3'd5;
   localparam logic [2:0] REG_SLEEP_MEDIUM_RISK = 3'd6;
   localparam logic [2:0] REG_SLEEP_LOW_RISK    = 3'd7;

   localparam logic [31:0] RST_OWN_NODE_ID       = 32'd0;
   localparam logic [31:0] RST_DEF_ALERT_DUR     = 32'd3600;
   localparam logic [31:0] RST_DEF_ALERT_IVL     = 32'd60;
   localparam logic [7:0]  RST_RISK_THR_MEDIUM   = 8'd70;
   localparam logic [7:0]  RST_RISK_THR_LOW      = 8'd40;
   localparam logic [31:0] RST_SLEEP_HIGH_RISK   = 32'd60;
   localparam logic [31:0] RST_SLEEP_MEDIUM_RISK = 32'd300;
   localparam logic [31:0] RST_SLEEP_LOW_RISK    = 32'd900;

   typedef struct packed {
      logic [31:0] own_node_id;
      logic [31:0] default_alert_duration;
      logic [31:0] default_alert_interval;
      logic [7:0]  risk_threshold_medium;
      logic [7:0]  risk_threshold_low;
      logic [31:0] sleep_high_risk;
      logic [31:0] sleep_medium_risk;
      logic [31:0] sleep_low_risk;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] advance_seconds;
      logic        anomaly_is_alert;
      logic [31:0] source_node;
      logic [31:0] duration_seconds;
      logic [31:0] interval_seconds;
      logic [7:0]  risk_level;
   } item_type;

   typedef struct packed {
      logic [31:0] now_seconds;
      logic        alert_mode_on;
      logic [31:0] alert_origin;
      logic [31:0] sleep_seconds_out;
   } result_type;

endpackage

`default_nettype wire

### hw/rtl/amss_csr.sv
// Configuration register file of the scheduler.
`timescale 1ns / 1ps
`default_nettype none

module amss_csr (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  wr_en,
   input  wire  [2:0]           wr_index,
   input  wire  [31:0]          wr_data,
   output amss_pkg::cfg_type    cfg
);

   amss_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_node_id            <= amss_pkg::RST_OWN_NODE_ID;
         cfg_ff.default_alert_duration <= amss_pkg::RST_DEF_ALERT_DUR;
         cfg_ff.default_alert_interval <= amss_pkg::RST_DEF_ALERT_IVL;
         cfg_ff.risk_threshold_medium  <= amss_pkg::RST_RISK_THR_MEDIUM;
         cfg_ff.risk_threshold_low     <= amss_pkg::RST_RISK_THR_LOW;
         cfg_ff.sleep_high_risk        <= amss_pkg::RST_SLEEP_HIGH_RISK;
         cfg_ff.sleep_medium_risk      <= amss_pkg::RST_SLEEP_MEDIUM_RISK;
         cfg_ff.sleep_low_risk         <= amss_pkg::RST_SLEEP_LOW_RISK;
      end else if (wr_en) begin
         unique case (wr_index)
            amss_pkg::REG_OWN_NODE_ID:       cfg_ff.own_node_id            <= wr_data;
            amss_pkg::REG_DEF_ALERT_DUR:     cfg_ff.default_alert_duration <= wr_data;
            amss_pkg::REG_DEF_ALERT_IVL:     cfg_ff.default_alert_interval <= wr_data;
            amss_pkg::REG_RISK_THR_MEDIUM:   cfg_ff.risk_threshold_medium  <= wr_data[7:0];
            amss_pkg::REG_RISK_THR_LOW:      cfg_ff.risk_threshold_low     <= wr_data[7:0];
            amss_pkg::REG_SLEEP_HIGH_RISK:   cfg_ff.sleep_high_risk        <= wr_data;
            amss_pkg::REG_SLEEP_MEDIUM_RISK: cfg_ff.sleep_medium_risk      <= wr_data;
            amss_pkg::REG_SLEEP_LOW_RISK:    cfg_ff.sleep_low_risk         <= wr_data;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### hw/rtl/amss_core.sv
// Scheduler state registers and the single-pass next-state logic.
`timescale 1ns / 1ps
`default_nettype none

module amss_core (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     advance,
   input  wire amss_pkg::item_type item,
   input  wire amss_pkg::cfg_type  cfg,
   output amss_pkg::result_type    result
);

   logic [31:0] clock_ff,    clock_in;
   logic        flag_ff,     flag_in;
   logic [31:0] expiry_ff,   expiry_in;
   logic [31:0] source_ff,   source_in;
   logic [31:0] interval_ff, interval_in;
   logic [31:0] sleep_ff,    sleep_in;

   logic        due;
   logic        exp_flag;
   logic [31:0] exp_expiry;
   logic [31:0] exp_source;
   logic [31:0] exp_interval;
   logic        local_arm;
   logic [31:0] arm_source;
   logic [31:0] arm_duration;
   logic [31:0] arm_ivl_raw;
   logic [31:0] arm_interval;
   logic [31:0] arm_expiry;

   always_comb begin
      // expiry view: drop alert mode once the clock reaches the expiry time
      due          = flag_ff && (clock_ff >= expiry_ff);
      exp_flag     = due ? 1'b0  : flag_ff;
      exp_expiry   = due ? 32'd0 : expiry_ff;
      exp_source   = due ? 32'd0 : source_ff;
      exp_interval = due ? cfg.default_alert_interval : interval_ff;

      local_arm    = (item.command == amss_pkg::CMD_ANOMALY);
      arm_source   = local_arm ? cfg.own_node_id : item.source_node;
      arm_duration = local_arm ? cfg.default_alert_duration : item.duration_seconds;
      arm_ivl_raw  = local_arm ? cfg.default_alert_interval : item.interval_seconds;
      arm_interval = (arm_ivl_raw != 32'd0) ? arm_ivl_raw : cfg.default_alert_interval;
      arm_expiry   = clock_ff + arm_duration;

      clock_in    = clock_ff;
      flag_in     = flag_ff;
      expiry_in   = expiry_ff;
      source_in   = source_ff;
      interval_in = interval_ff;
      sleep_in    = sleep_ff;

      unique case (item.command)
         amss_pkg::CMD_ADVANCE: begin
            clock_in = clock_ff + item.advance_seconds;
         end
         amss_pkg::CMD_ANOMALY, amss_pkg::CMD_REMOTE: begin
            if (local_arm && !item.anomaly_is_alert) begin
               flag_in     = exp_flag;
               expiry_in   = exp_expiry;
               source_in   = exp_source;
               interval_in = exp_interval;
            end else begin
               flag_in     = (arm_duration != 32'd0);
               expiry_in   = arm_expiry;
               source_in   = arm_source;
               interval_in = arm_interval;
            end
         end
         amss_pkg::CMD_RISK: begin
            flag_in     = exp_flag;
            expiry_in   = exp_expiry;
            source_in   = exp_source;
            interval_in = exp_interval;
            priority if (exp_flag) begin
               sleep_in = (exp_interval != 32'd0) ? exp_interval : cfg.default_alert_interval;
            end else if (item.risk_level >= cfg.risk_threshold_medium) begin
               sleep_in = cfg.sleep_high_risk;
            end else if (item.risk_level >= cfg.risk_threshold_low) begin
               sleep_in = cfg.sleep_medium_risk;
            end else begin
               sleep_in = cfg.sleep_low_risk;
            end
         end
      endcase

      result.now_seconds       = clock_in;
      result.alert_mode_on     = flag_in && (clock_in < expiry_in);
      result.alert_origin      = source_in;
      result.sleep_seconds_out = sleep_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_ff    <= 32'd0;
         flag_ff     <= 1'b0;
         expiry_ff   <= 32'd0;
         source_ff   <= 32'd0;
         interval_ff <= amss_pkg::RST_DEF_ALERT_IVL;
         sleep_ff    <= amss_pkg::RST_SLEEP_LOW_RISK;
      end else if (advance) begin
         clock_ff    <= clock_in;
         flag_ff     <= flag_in;
         expiry_ff   <= expiry_in;
         source_ff   <= source_in;
         interval_ff <= interval_in;
         sleep_ff    <= sleep_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/alert_mode_sleep_scheduler_top.sv
// Top level of the alert mode sleep scheduler: input register, core, result register.
// One command per clock cycle sustained while rsp_stall is low. An accepted transaction is
// taken into the input register, passes the scheduler logic and lands in the result
// register once that register is free (empty or not stalled), which raises rsp_valid.
// These two registers lie on the path; req_stall rises only when both hold a transaction
// and rsp_stall is high. Configuration writes are always taken (csr_ready is always
// high) and belong to times when no transaction is in flight.
`timescale 1ns / 1ps
`default_nettype none

module alert_mode_sleep_scheduler_top (
   input  wire         clock,
   input  wire         reset,

   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [1:0]  req_command,
   input  wire  [31:0] req_advance_seconds,
   input  wire         req_anomaly_is_alert,
   input  wire  [31:0] req_source_node,
   input  wire  [31:0] req_duration_seconds,
   input  wire  [31:0] req_interval_seconds,
   input  wire  [7:0]  req_risk_level,

   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [31:0] rsp_now_seconds,
   output logic        rsp_alert_mode_on,
   output logic [31:0] rsp_alert_origin,
   output logic [31:0] rsp_sleep_seconds_out,

   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [2:0]  csr_index,
   input  wire  [31:0] csr_wdata
);

   amss_pkg::cfg_type    cfg;
   amss_pkg::item_type   in_item_ff;
   amss_pkg::result_type core_result;
   amss_pkg::result_type out_data_ff;

   logic in_valid_ff, in_valid_in;
   logic out_valid_ff, out_valid_in;
   logic out_free;
   logic in_move;
   logic req_accept;

   assign csr_ready = 1'b1;

   amss_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   amss_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (in_move),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (core_result)
   );

   always_comb begin
      out_free     = !out_valid_ff || !rsp_stall;
      in_move      = in_valid_ff && out_free;
      req_stall    = in_valid_ff && !out_free;
      req_accept   = req_valid && !req_stall;
      // hold the input transaction while the result register is blocked
      in_valid_in  = req_stall ? 1'b1 : req_accept;
      out_valid_in = in_move ? 1'b1 : (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff.command          <= req_command;
         in_item_ff.advance_seconds  <= req_advance_seconds;
         in_item_ff.anomaly_is_alert <= req_anomaly_is_alert;
         in_item_ff.source_node      <= req_source_node;
         in_item_ff.duration_seconds <= req_duration_seconds;
         in_item_ff.interval_seconds <= req_interval_seconds;
         in_item_ff.risk_level       <= req_risk_level;
      end
      if (in_move) begin
         out_data_ff <= core_result;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_now_seconds       = out_data_ff.now_seconds;
   assign rsp_alert_mode_on     = out_data_ff.alert_mode_on;
   assign rsp_alert_origin      = out_data_ff.alert_origin;
   assign rsp_sleep_seconds_out = out_data_ff.sleep_seconds_out;

endmodule

`default_nettype wire

### hw/rtl/amss_checker.sv
// Port-level checker of the scheduler and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "alert_mode_sleep_scheduler_top_macros.svh"

module amss_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_stall,
   input wire        rsp_valid,
   input wire        rsp_stall,
   input wire [31:0] rsp_now_seconds,
   input wire [31:0] rsp_sleep_seconds_out
);

   // reset empties both registers
   `AMSS_ASSERT_RESET(a_reset_empty, reset, !rsp_valid && !req_stall)

   // input side stalls only when the result side is full and stalled
   `AMSS_ASSERT_NOW(a_stall_cause, !rsp_valid || !rsp_stall, !req_stall)

   // an accepted transaction reaches the result port when rsp_stall does not block it
   `AMSS_ASSERT_NEXT(a_latency, (req_valid && !req_stall) ##1 !rsp_stall, rsp_valid)

   // a stalled result holds
   `AMSS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_now_seconds) && $stable(rsp_sleep_seconds_out))

endmodule

bind alert_mode_sleep_scheduler_top amss_checker u_amss_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_valid),
   .req_stall             (req_stall),
   .rsp_valid             (rsp_valid),
   .rsp_stall             (rsp_stall),
   .rsp_now_seconds       (rsp_now_seconds),
   .rsp_sleep_seconds_out (rsp_sleep_seconds_out)
);

`default_nettype wire
